// ----- rtl/lsp_pkg.sv -----
package lsp_pkg;

    localparam int ADC_BITS   = 12;
    localparam int NSENS      = 5;
    localparam int CAL_BITS   = 12;
    localparam int CAL_MAX    = 4095;
    localparam int CENTROID_K = 17;
    localparam int FRAC_BITS  = 8;

    localparam int SENS_HI [NSENS] = '{3480, 3220, 3485, 3420, 3450};
    localparam int SENS_LO [NSENS] = '{214, 203, 289, 259, 350};
    localparam int SENS_W  [NSENS] = '{
        SENS_HI[0] - SENS_LO[0], SENS_HI[1] - SENS_LO[1], SENS_HI[2] - SENS_LO[2],
        SENS_HI[3] - SENS_LO[3], SENS_HI[4] - SENS_LO[4]
    };

    // Exact quotient for dividends below 2**24 with divisors below 2**12.
    localparam int CAL_SHIFT = 36;
    localparam int RECIP_W   = 25;
    localparam longint CAL_RECIP [NSENS] = '{
        ((longint'(1) <<< CAL_SHIFT) + SENS_W[0] - 1) / SENS_W[0],
        ((longint'(1) <<< CAL_SHIFT) + SENS_W[1] - 1) / SENS_W[1],
        ((longint'(1) <<< CAL_SHIFT) + SENS_W[2] - 1) / SENS_W[2],
        ((longint'(1) <<< CAL_SHIFT) + SENS_W[3] - 1) / SENS_W[3],
        ((longint'(1) <<< CAL_SHIFT) + SENS_W[4] - 1) / SENS_W[4]
    };

    localparam int SPAN_W = CAL_BITS + 1;
    localparam int BASE_W = 24;
    localparam int PROD_W = SPAN_W + ADC_BITS + 1;
    localparam int V_W    = (PROD_W > BASE_W + 1 ? PROD_W : BASE_W + 1) + 1;
    localparam int QV_W   = CAL_BITS + 12;
    localparam int SUM_W  = CAL_BITS + 3;
    localparam int LIN_W  = CAL_BITS + 3;
    localparam int NUM_W  = LIN_W + 5;
    localparam int DVD_W  = NUM_W - 1 + FRAC_BITS;
    localparam int QUO_W  = 14;
    localparam int CMP_W  = SUM_W + QUO_W + 1;
    localparam int X_W    = QUO_W + 1;
    localparam int GAIN_W = 16;
    localparam int PRD_W  = GAIN_W + X_W;
    localparam int E_W    = PRD_W - FRAC_BITS + 2;
    localparam int OUT_W  = 24;
    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Y_MIN,
        CFG_Y_MAX,
        CFG_LINE_GAIN,
        CFG_LINE_OFFSET
    } t_cfg_idx;

    typedef struct packed {
        logic [ADC_BITS-1:0] raw_outer_left;
        logic [ADC_BITS-1:0] raw_inner_left;
        logic [ADC_BITS-1:0] raw_center;
        logic [ADC_BITS-1:0] raw_inner_right;
        logic [ADC_BITS-1:0] raw_outer_right;
    } t_in_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] position_error;
        logic                    sum_zero;
    } t_out_req;

endpackage

// ----- rtl/line_sensor_position_error.sv -----
// Line sensor position error, fully pipelined.
//
// Input channel: i_in_valid / o_in_ready with i_in_req carrying five raw
// readings, left to right. Output channel: o_out_valid / i_out_ready with
// o_out_req carrying the signed Q.8 position error and the zero-sum flag.
// Configuration: a write at any clock edge with i_cfg_we high loads the
// register selected by i_cfg_idx (y_min, y_max, line_gain, line_offset).
//
// One request can be accepted every cycle unless the pipeline is stalled.
// The depth is set by the calibration multipliers and the 14-stage
// restoring divider, one quotient bit a stage.
//
// When the receiver stalls, each stage holds while the stage after it is
// full, empty stages keep filling, and o_in_ready drops only once all 23
// stages hold a request. Reset empties the pipeline and loads the register
// reset values; it takes effect at the next clock edge.
module line_sensor_position_error (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lsp_pkg::t_in_req               i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lsp_pkg::t_out_req              o_out_req,
    input  logic                           i_cfg_we,
    input  logic [lsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsp_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import lsp_pkg::*;

    localparam int ST_D    = 0;
    localparam int ST_PROD = 1;
    localparam int ST_V    = 2;
    localparam int ST_Q    = 3;
    localparam int ST_SUM  = 4;
    localparam int ST_DVD  = 5;
    localparam int ST_DIV0 = 6;
    localparam int ST_X    = ST_DIV0 + QUO_W;
    localparam int ST_MUL  = ST_X + 1;
    localparam int ST_OUT  = ST_MUL + 1;
    localparam int NST     = ST_OUT + 1;

    localparam logic signed [E_W-1:0] E_MAX = E_W'(OUT_MAX);
    localparam logic signed [E_W-1:0] E_MIN = E_W'(OUT_MIN);

    logic [CAL_BITS-1:0]      r_y_min;
    logic [CAL_BITS-1:0]      r_y_max;
    logic signed [GAIN_W-1:0] r_line_gain;
    logic signed [GAIN_W-1:0] r_line_offset;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_min       <= '0;
            r_y_max       <= CAL_BITS'(CAL_MAX);
            r_line_gain   <= GAIN_W'(256);
            r_line_offset <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_Y_MIN:       r_y_min       <= i_cfg_wdata[CAL_BITS-1:0];
                CFG_Y_MAX:       r_y_max       <= i_cfg_wdata[CAL_BITS-1:0];
                CFG_LINE_GAIN:   r_line_gain   <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                CFG_LINE_OFFSET: r_line_offset <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    assign w_en[NST-1] = !r_vld[NST-1] || i_out_ready;
    for (genvar g = 0; g < NST - 1; g++) begin : g_en
        assign w_en[g] = !r_vld[g] || w_en[g+1];
    end

    assign o_in_ready  = w_en[ST_D];
    assign o_out_valid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[ST_D]) begin
                r_vld[ST_D] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Offset from the sensor minimum, span and base term.
    logic [ADC_BITS-1:0]        w_raw  [NSENS];
    logic signed [ADC_BITS:0]   w_dif  [NSENS];
    logic [ADC_BITS-1:0]        n_d    [NSENS];
    logic [BASE_W-1:0]          n_base [NSENS];
    logic signed [SPAN_W-1:0]   n_span;
    logic [ADC_BITS-1:0]        r_d    [NSENS];
    logic [BASE_W-1:0]          r_base0[NSENS];
    logic signed [SPAN_W-1:0]   r_span;

    assign w_raw[0] = i_in_req.raw_outer_left;
    assign w_raw[1] = i_in_req.raw_inner_left;
    assign w_raw[2] = i_in_req.raw_center;
    assign w_raw[3] = i_in_req.raw_inner_right;
    assign w_raw[4] = i_in_req.raw_outer_right;

    always_comb begin
        n_span = $signed({1'b0, r_y_max}) - $signed({1'b0, r_y_min});
        for (int s = 0; s < NSENS; s++) begin
            w_dif[s]  = $signed({1'b0, w_raw[s]}) - $signed((ADC_BITS + 1)'(SENS_LO[s]));
            n_d[s]    = w_dif[s][ADC_BITS] ? '0 : w_dif[s][ADC_BITS-1:0];
            n_base[s] = BASE_W'(r_y_min * SENS_W[s]);
        end
    end

    // Slope product.
    logic signed [PROD_W-1:0] r_prod [NSENS];
    logic [BASE_W-1:0]        r_base1[NSENS];

    // Numerator flags and low bits.
    logic signed [V_W-1:0]    w_v    [NSENS];
    logic                     n_vneg [NSENS];
    logic                     n_vsat [NSENS];
    logic                     r_vneg [NSENS];
    logic                     r_vsat [NSENS];
    logic [QV_W-1:0]          r_vlo  [NSENS];

    always_comb begin
        for (int s = 0; s < NSENS; s++) begin
            w_v[s]    = V_W'(r_prod[s]) + $signed(V_W'(r_base1[s]));
            n_vneg[s] = w_v[s][V_W-1];
            n_vsat[s] = w_v[s] >= $signed(V_W'(SENS_W[s] * (CAL_MAX + 1)));
        end
    end

    // Division by the sensor width through a reciprocal.
    logic [QV_W+RECIP_W-1:0]  w_qprod[NSENS];
    logic [CAL_BITS-1:0]      n_c    [NSENS];
    logic [CAL_BITS-1:0]      r_c    [NSENS];

    always_comb begin
        for (int s = 0; s < NSENS; s++) begin
            w_qprod[s] = r_vlo[s] * RECIP_W'(CAL_RECIP[s]);
            if (r_vneg[s]) begin
                n_c[s] = '0;
            end else if (r_vsat[s]) begin
                n_c[s] = CAL_BITS'(CAL_MAX);
            end else begin
                n_c[s] = w_qprod[s][CAL_SHIFT +: CAL_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_D]) begin
            r_span <= n_span;
            for (int s = 0; s < NSENS; s++) begin
                r_d[s]     <= n_d[s];
                r_base0[s] <= n_base[s];
            end
        end
        if (w_en[ST_PROD]) begin
            for (int s = 0; s < NSENS; s++) begin
                r_prod[s]  <= r_span * $signed({1'b0, r_d[s]});
                r_base1[s] <= r_base0[s];
            end
        end
        if (w_en[ST_V]) begin
            for (int s = 0; s < NSENS; s++) begin
                r_vneg[s] <= n_vneg[s];
                r_vsat[s] <= n_vsat[s];
                r_vlo[s]  <= w_v[s][QV_W-1:0];
            end
        end
        if (w_en[ST_Q]) begin
            for (int s = 0; s < NSENS; s++) begin
                r_c[s] <= n_c[s];
            end
        end
    end

    // Sum and weighted numerator.
    logic signed [LIN_W-1:0] w_cs [NSENS];
    logic signed [LIN_W-1:0] w_lin;
    logic signed [NUM_W-1:0] n_num;
    logic [SUM_W-1:0]        n_sum;
    logic signed [NUM_W-1:0] r_num;
    logic [SUM_W-1:0]        r_sum;

    always_comb begin
        n_sum = '0;
        for (int s = 0; s < NSENS; s++) begin
            w_cs[s] = $signed(LIN_W'(r_c[s]));
            n_sum   = n_sum + SUM_W'(r_c[s]);
        end
        w_lin = ((w_cs[4] - w_cs[0]) <<< 1) + (w_cs[3] - w_cs[1]);
        n_num = (NUM_W'(w_lin) <<< 4) + NUM_W'(w_lin);
    end

    // Divider setup.
    logic [NUM_W-1:0] w_mag;
    logic [DVD_W-1:0] r_dvd;
    logic [SUM_W-1:0] r_dsr;
    logic             r_dneg;
    logic             r_dzero;

    assign w_mag = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_num <= n_num;
            r_sum <= n_sum;
        end
        if (w_en[ST_DVD]) begin
            r_dvd   <= {w_mag[NUM_W-2:0], FRAC_BITS'(0)};
            r_dsr   <= r_sum;
            r_dneg  <= r_num[NUM_W-1];
            r_dzero <= (r_sum == '0);
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    logic [DVD_W-1:0] r_rem  [QUO_W];
    logic [QUO_W-1:0] r_quo  [QUO_W];
    logic [SUM_W-1:0] r_qdsr [QUO_W];
    logic             r_qneg [QUO_W];
    logic             r_qzero[QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        logic [DVD_W-1:0] w_rem_in;
        logic [QUO_W-1:0] w_quo_in;
        logic [SUM_W-1:0] w_dsr_in;
        logic             w_neg_in;
        logic             w_zero_in;
        logic [CMP_W-1:0] w_trial;
        logic             w_bit;

        if (j == 0) begin : g_first
            assign w_rem_in  = r_dvd;
            assign w_quo_in  = '0;
            assign w_dsr_in  = r_dsr;
            assign w_neg_in  = r_dneg;
            assign w_zero_in = r_dzero;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_quo_in  = r_quo[j-1];
            assign w_dsr_in  = r_qdsr[j-1];
            assign w_neg_in  = r_qneg[j-1];
            assign w_zero_in = r_qzero[j-1];
        end

        assign w_trial = CMP_W'(w_rem_in) - (CMP_W'(w_dsr_in) << (QUO_W - 1 - j));
        assign w_bit   = !w_trial[CMP_W-1];

        always_ff @(posedge i_clk) begin
            if (w_en[ST_DIV0 + j]) begin
                r_rem[j]   <= w_bit ? w_trial[DVD_W-1:0] : w_rem_in;
                r_quo[j]   <= {w_quo_in[QUO_W-2:0], w_bit};
                r_qdsr[j]  <= w_dsr_in;
                r_qneg[j]  <= w_neg_in;
                r_qzero[j] <= w_zero_in;
            end
        end
    end

    // Signed centroid, gain and offset.
    logic signed [X_W-1:0]   w_xmag;
    logic signed [X_W-1:0]   r_x;
    logic                    r_xzero;
    logic signed [PRD_W-1:0] r_prd;
    logic                    r_mzero;
    logic signed [E_W-1:0]   w_e;
    t_out_req                n_out;
    t_out_req                r_out;

    assign w_xmag = $signed({1'b0, r_quo[QUO_W-1]});

    always_comb begin
        w_e = E_W'(r_prd >>> FRAC_BITS) - E_W'(r_line_offset);
        n_out.sum_zero = r_mzero;
        if (r_mzero) begin
            n_out.position_error = '0;
        end else if (w_e > E_MAX) begin
            n_out.position_error = OUT_W'(OUT_MAX);
        end else if (w_e < E_MIN) begin
            n_out.position_error = OUT_W'(OUT_MIN);
        end else begin
            n_out.position_error = w_e[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_X]) begin
            r_x     <= r_qneg[QUO_W-1] ? -w_xmag : w_xmag;
            r_xzero <= r_qzero[QUO_W-1];
        end
        if (w_en[ST_MUL]) begin
            r_prd   <= r_line_gain * r_x;
            r_mzero <= r_xzero;
        end
        if (w_en[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_out_req = r_out;

endmodule

// ----- rtl/lsp_checker.sv -----
module lsp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input lsp_pkg::t_out_req o_out_req
);
    import lsp_pkg::*;

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output request dropped before it was taken.");

    a_out_req_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_req))
        else $error("Output request changed while stalled.");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("Input refused while the output is moving.");

    a_zero_sum_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.sum_zero |-> o_out_req.position_error == '0)
        else $error("Zero sum with a nonzero position error.");

endmodule

bind line_sensor_position_error lsp_checker u_lsp_checker (.*);
